/* design/sss_pkg.sv */
// Shared types, register indexes and lookup tables for the selective state scan.
package sss_pkg;

  localparam logic [1:0] REG_SOFTPLUS = 2'd0;
  localparam logic [1:0] REG_SKIP     = 2'd1;
  localparam logic [1:0] REG_GATE     = 2'd2;

  localparam int IN_BYTES  = 18;
  localparam int OUT_BYTES = 5;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_MOD, ST_SP0, ST_SP1, ST_A0, ST_A1,
    ST_EXP_P, ST_EXP_I, ST_EXP_V, ST_B0, ST_B1, ST_B2, ST_X1, ST_X2,
    ST_Y0, ST_Y1, ST_DIV0, ST_DIV1, ST_G2, ST_G3, ST_G4, ST_OUT
  } st_t;

  typedef struct packed {
    logic        start;
    logic [32:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] quot;
  } div_rsp_t;

  // ln(1+e^-t), Q12, step 0.5
  function automatic logic [11:0] lnp_at(input logic [4:0] i);
    logic [11:0] r;
    case (i)
      5'd0: r = 12'd2839;  5'd1: r = 12'd1942;  5'd2: r = 12'd1283;
      5'd3: r = 12'd825;   5'd4: r = 12'd520;   5'd5: r = 12'd323;
      5'd6: r = 12'd199;   5'd7: r = 12'd122;   5'd8: r = 12'd74;
      5'd9: r = 12'd45;    5'd10: r = 12'd28;   5'd11: r = 12'd17;
      5'd12: r = 12'd10;   5'd13: r = 12'd6;    5'd14: r = 12'd4;
      5'd15: r = 12'd2;    5'd16: r = 12'd1;
      default: r = 12'd0;
    endcase
    return r;
  endfunction

  // 2^(i/16), Q16
  function automatic logic [17:0] pow2_at(input logic [4:0] i);
    logic [17:0] r;
    case (i)
      5'd0: r = 18'd65536;   5'd1: r = 18'd68438;   5'd2: r = 18'd71468;
      5'd3: r = 18'd74632;   5'd4: r = 18'd77936;   5'd5: r = 18'd81386;
      5'd6: r = 18'd84990;   5'd7: r = 18'd88752;   5'd8: r = 18'd92682;
      5'd9: r = 18'd96785;   5'd10: r = 18'd101070; 5'd11: r = 18'd105545;
      5'd12: r = 18'd110218; 5'd13: r = 18'd115098; 5'd14: r = 18'd120194;
      5'd15: r = 18'd125515; 5'd16: r = 18'd131072;
      default: r = 18'd0;
    endcase
    return r;
  endfunction

endpackage

/* design/sss_mul.sv */
// Shared signed multiplier with registered product.
module sss_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

/* design/sss_div.sv */
// Restoring divider, one quotient bit per cycle: 2^32 / divisor.
module sss_div (
  input  logic                clk,
  input  logic                rst,
  input  sss_pkg::div_req_t   req,
  output sss_pkg::div_rsp_t   rsp
);
  import sss_pkg::*;

  logic [32:0] num;
  logic [33:0] rem;
  logic [32:0] quo;
  logic [32:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic        done_r;
  logic [33:0] trial;
  logic [34:0] diff;

  always_comb begin
    trial = {rem[32:0], num[32]};
    diff  = {1'b0, trial} - {2'b00, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        num  <= 33'h1_0000_0000;
        rem  <= '0;
        quo  <= '0;
        dvs  <= req.divisor;
        cnt  <= 6'd33;
      end else if (busy) begin
        num <= {num[31:0], 1'b0};
        if (!diff[34]) begin
          rem <= diff[33:0];
          quo <= {quo[31:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[31:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp = {done_r, quo[16:0]};
endmodule

/* design/selective_state_scan.sv */
// Top level: sequencer, hidden-state memory and datapath around one shared multiplier.
// Flow: s_tready stays low after a transfer until the element is done, longer with softplus;
//   a last element then runs the output states up to m_tvalid, longer with gating (divider).
// Throughput: one element at a time; a result held by m_tready low also holds the input.
// Reset (rst, synchronous): clears config, accumulator and clip flag, then runs a clearing
//   pass that zeroes each of the CHANNELS*STATES hidden-state entries with s_tready low.
module selective_state_scan #(
  parameter int CHANNELS = 64,
  parameter int STATES   = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // channel, state_index, step_raw, step_bias, u_val, a_coef, b_val, c_val, d_skip,
  // z_val, zero pad
  input  logic [143:0] s_tdata,
  input  logic         s_tlast,   // last_element
  input  logic         s_tuser,   // seq_start
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [39:0]  m_tdata,   // channel_out, y_value, zero pad
  output logic         m_tuser,   // saturated
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic         cfg_wdata
);
  import sss_pkg::*;

  localparam int DEPTH = CHANNELS * STATES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic signed [39:0] ACC_MAX = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] ACC_MIN = {1'b1, {39{1'b0}}};

  st_t state, state_next;

  logic softplus_on, skip_on, gate_on;

  logic [5:0]  ch_in, ch_m;
  logic [3:0]  si_m;
  logic        start_r, last_r;
  logic signed [15:0] raw_r, bias_r, u_r, a_r, b_r, c_r, d_r, z_r;
  logic signed [17:0] dt;
  logic [11:0] gbase;
  logic        gvalid;
  logic signed [21:0] w_r;
  logic        exp_ret;
  logic signed [11:0] exp_n;
  logic [17:0] exp_base;
  logic [31:0] exp_res;
  logic signed [31:0] dbu;
  logic signed [31:0] rd_data;
  logic signed [39:0] acc;
  logic        clip_seen;
  logic signed [63:0] y_r;
  logic signed [21:0] silu;
  logic signed [39:0] lowprod;
  logic [AW-1:0] clr_cnt;

  logic [31:0] mem [DEPTH];
  logic [AW-1:0] addr;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  div_req_t div_req;
  div_rsp_t div_rsp;

  sss_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));
  sss_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  assign addr = AW'(32'(ch_m) * STATES + 32'(si_m));

  // datapath helpers
  logic [17:0] t_abs;
  logic [4:0]  sp_i, ex_i;
  logic signed [18:0] exp_v;
  logic [31:0] exp_out;
  logic [4:0]  rsh;
  logic signed [50:0] xsum;
  logic signed [31:0] xnew;
  logic        xclip;
  logic signed [54:0] asum;
  logic signed [63:0] gfull;
  logic signed [31:0] ysat;
  logic        yclip;

  always_comb begin
    t_abs = (dt < 0) ? 18'(-dt) : 18'(dt);
    sp_i  = {1'b0, t_abs[14:11]};
    ex_i  = {1'b0, mul_p[23:20]};
    exp_v = 19'(exp_base) + 19'(mul_p >>> 8);
    rsh   = 5'(-exp_n);
    if (exp_n >= 12'sd15) exp_out = 32'h7FFF_FFFF;
    else if (exp_n >= 12'sd0) exp_out = 32'(exp_v) << exp_n[3:0];
    else if (exp_n <= -12'sd32) exp_out = '0;
    else exp_out = 32'(exp_v) >> rsh;

    xsum = 51'($signed(mul_p[65:16])) + 51'(dbu);
    xclip = 1'b0;
    if (xsum > 51'sd2147483647) begin
      xnew = 32'sh7FFF_FFFF; xclip = 1'b1;
    end else if (xsum < -51'sd2147483648) begin
      xnew = 32'sh8000_0000; xclip = 1'b1;
    end else xnew = xsum[31:0];

    asum  = 55'($signed(mul_p[65:12])) + 55'(acc);
    gfull = 64'({mul_p[46:0], 17'b0}) + 64'(lowprod);

    yclip = 1'b0;
    if (y_r > 64'sd2147483647) begin
      ysat = 32'sh7FFF_FFFF; yclip = 1'b1;
    end else if (y_r < -64'sd2147483648) begin
      ysat = 32'sh8000_0000; yclip = 1'b1;
    end else ysat = y_r[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLR;
    else state <= state_next;
  end

  always_comb begin
    state_next      = state;
    mul_a           = '0;
    mul_b           = '0;
    div_req.start   = 1'b0;
    div_req.divisor = 33'd65536 + 33'(exp_res);
    s_tready        = 1'b0;
    unique case (state)
      ST_CLR: if (32'(clr_cnt) == DEPTH - 1) state_next = ST_IDLE;
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = ST_MOD;
      end
      ST_MOD:
        if (32'(ch_m) < CHANNELS && 32'(si_m) < STATES)
          state_next = softplus_on ? ST_SP0 : ST_A0;
      ST_SP0: begin
        mul_a = 33'(lnp_at(sp_i)) - 33'(lnp_at(sp_i + 5'd1));
        mul_b = 33'(t_abs[10:0]);
        state_next = ST_SP1;
      end
      ST_SP1: state_next = ST_A0;
      ST_A0: begin
        mul_a = 33'(dt);
        mul_b = 33'(a_r);
        state_next = ST_A1;
      end
      ST_A1: state_next = ST_EXP_P;
      ST_EXP_P: begin
        mul_a = 33'(w_r);
        mul_b = 33'sd5909;
        state_next = ST_EXP_I;
      end
      ST_EXP_I: begin
        mul_a = 33'(pow2_at(ex_i + 5'd1)) - 33'(pow2_at(ex_i));
        mul_b = 33'(mul_p[19:12]);
        state_next = ST_EXP_V;
      end
      ST_EXP_V: state_next = exp_ret ? ST_DIV0 : ST_B0;
      ST_B0: begin
        mul_a = 33'(b_r);
        mul_b = 33'(u_r);
        state_next = ST_B1;
      end
      ST_B1: begin
        mul_a = 33'($signed(mul_p[31:0]));
        mul_b = 33'(dt);
        state_next = ST_B2;
      end
      ST_B2: begin
        mul_a = {1'b0, exp_res};
        mul_b = start_r ? 33'sd0 : 33'(rd_data);
        state_next = ST_X1;
      end
      ST_X1: begin
        mul_a = 33'(c_r);
        mul_b = 33'(xnew);
        state_next = ST_X2;
      end
      ST_X2: state_next = last_r ? ST_Y0 : ST_IDLE;
      ST_Y0: begin
        mul_a = 33'(d_r);
        mul_b = 33'(u_r);
        state_next = ST_Y1;
      end
      ST_Y1: state_next = gate_on ? ST_EXP_P : ST_OUT;
      ST_DIV0: begin
        div_req.start = 1'b1;
        state_next = ST_DIV1;
      end
      ST_DIV1: begin
        mul_a = 33'(z_r);
        mul_b = 33'(div_rsp.quot);
        if (div_rsp.done) state_next = ST_G2;
      end
      ST_G2: begin
        mul_a = {16'b0, y_r[16:0]};
        mul_b = 33'($signed(mul_p[33:12]));
        state_next = ST_G3;
      end
      ST_G3: begin
        mul_a = y_r[49:17];
        mul_b = 33'(silu);
        state_next = ST_G4;
      end
      ST_G4: state_next = ST_OUT;
      ST_OUT: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default: state_next = ST_CLR;
    endcase
  end

  assign ch_in = s_tdata[5:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      softplus_on <= 1'b0;
      skip_on     <= 1'b0;
      gate_on     <= 1'b0;
      acc         <= '0;
      clip_seen   <= 1'b0;
      m_tvalid    <= 1'b0;
      clr_cnt     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_SOFTPLUS: softplus_on <= cfg_wdata;
          REG_SKIP:     skip_on     <= cfg_wdata;
          REG_GATE:     gate_on     <= cfg_wdata;
          default: ;
        endcase
      end
      if (state == ST_CLR) clr_cnt <= clr_cnt + AW'(1);
      if (state == ST_X1 && xclip) clip_seen <= 1'b1;
      if (state == ST_X2) begin
        if (asum > 55'(ACC_MAX)) begin
          acc <= ACC_MAX; clip_seen <= 1'b1;
        end else if (asum < 55'(ACC_MIN)) begin
          acc <= ACC_MIN; clip_seen <= 1'b1;
        end else acc <= asum[39:0];
      end
      if (state == ST_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid  <= 1'b1;
        acc       <= '0;
        clip_seen <= 1'b0;
      end else if (m_tready) begin
        m_tvalid  <= 1'b0;
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (s_tvalid) begin
        ch_m    <= ch_in;
        si_m    <= s_tdata[9:6];
        start_r <= s_tuser;
        last_r  <= s_tlast;
        raw_r   <= s_tdata[25:10];
        bias_r  <= s_tdata[41:26];
        u_r     <= s_tdata[57:42];
        a_r     <= s_tdata[73:58];
        b_r     <= s_tdata[89:74];
        c_r     <= s_tdata[105:90];
        d_r     <= s_tdata[121:106];
        z_r     <= s_tdata[137:122];
        exp_ret <= 1'b0;
      end
      ST_MOD: begin
        if (32'(ch_m) >= CHANNELS) ch_m <= 6'(32'(ch_m) - CHANNELS);
        if (32'(si_m) >= STATES) si_m <= 4'(32'(si_m) - STATES);
        dt <= 18'(raw_r) + 18'(bias_r);
      end
      ST_SP0: begin
        gbase  <= lnp_at(sp_i);
        gvalid <= (t_abs[17:15] == 3'd0);
      end
      ST_SP1:
        dt <= ((dt > 0) ? dt : 18'sd0)
            + (gvalid ? 18'(18'(gbase) - 18'(mul_p >>> 11)) : 18'sd0);
      ST_A0: rd_data <= mem[addr];
      ST_A1: w_r <= mul_p[33:12];
      ST_EXP_I: begin
        exp_n    <= mul_p[35:24];
        exp_base <= pow2_at(ex_i);
      end
      ST_EXP_V: exp_res <= exp_out;
      ST_B2: dbu <= mul_p[51:20];
      ST_Y1: begin
        y_r     <= 64'(acc) + (skip_on ? 64'($signed(mul_p[65:8])) : 64'sd0);
        w_r     <= -22'(z_r);
        exp_ret <= 1'b1;
      end
      ST_G2: silu <= mul_p[33:12];
      ST_G3: lowprod <= mul_p[39:0];
      ST_G4: y_r <= gfull >>> 16;
      ST_OUT: if (!m_tvalid || m_tready) begin
        m_tdata <= {2'b00, ysat, ch_m};
        m_tuser <= clip_seen | yclip;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLR) mem[clr_cnt] <= '0;
    else if (state == ST_X1) mem[addr] <= xnew;
  end

endmodule

/* design/sss_checker.sv */
// Port-level checks for the selective state scan, bound to the top level.
module sss_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [39:0]  m_tdata,
  input logic         m_tuser
);
  // clearing pass keeps input closed right after reset
  a_clr: assert property (@(posedge clk) $past(rst) && !rst |-> !s_tready)
    else $error("input ready during memory clear");

  // one item at a time
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after a transfer");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped before transfer");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");
endmodule

bind selective_state_scan sss_checker u_sss_checker (.*);

/* tb/tb_top.sv */
// Self-checking testbench for the selective state scan: directed and random element streams.
`timescale 1ns / 100ps

module tb_top;
  import sss_pkg::*;

  localparam int NCH = 64;
  localparam int NST = 16;

  typedef struct packed {
    logic [5:0]  channel;
    logic [3:0]  state_index;
    logic        seq_start;
    logic        last_element;
    logic signed [15:0] step_raw;
    logic signed [15:0] step_bias;
    logic signed [15:0] u_val;
    logic signed [15:0] a_coef;
    logic signed [15:0] b_val;
    logic signed [15:0] c_val;
    logic signed [15:0] d_skip;
    logic signed [15:0] z_val;
  } element_t;

  localparam int EW = $bits(element_t);

  typedef struct packed {
    logic [5:0]  channel_out;
    logic [31:0] y_value;
    logic        saturated;
  } scan_out_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic         s_tlast = 1'b0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [39:0]  m_tdata;
  logic         m_tuser;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_addr = '0;
  logic         cfg_wdata = 1'b0;

  selective_state_scan #(.CHANNELS(NCH), .STATES(NST)) DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  longint hstate [NCH*NST];
  longint acc_q;
  bit     clip_q;
  bit     sp_en, skip_en, gate_en;
  scan_out_t y_expected[$];
  int     errors = 0;
  int     y_seen = 0;
  int     items_sent = 0;
  bit     calm = 1'b0;  // no idling on either side

  const int LNP [17] = '{2839, 1942, 1283, 825, 520, 323, 199, 122, 74,
                         45, 28, 17, 10, 6, 4, 2, 1};
  const int POW2 [17] = '{65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752,
                          92682, 96785, 101070, 105545, 110218, 115098, 120194,
                          125515, 131072};

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip32(longint v, ref bit flag);
    if (v > 64'sd2147483647) begin flag = 1; return 64'sd2147483647; end
    if (v < -64'sd2147483648) begin flag = 1; return -64'sd2147483648; end
    return v;
  endfunction

  function automatic longint softplus(longint x);
    longint t, g, i, fr;
    t = x < 0 ? -x : x;
    g = 0;
    if (t < 32768) begin
      i = t >> 11;
      fr = t & 2047;
      g = LNP[i] - shr((LNP[i] - LNP[i+1]) * fr, 11);
    end
    return (x > 0 ? x : 0) + g;
  endfunction

  function automatic longint exp2q(longint w);
    longint p, n, f, i, fr, v;
    p = shr(w * 5909, 12);
    n = shr(p, 12);
    f = p - n * 4096;
    i = f >> 8;
    fr = f & 255;
    v = POW2[i] + shr((POW2[i+1] - POW2[i]) * fr, 8);
    if (n >= 15) return 64'sd2147483647;
    if (n >= 0) return v << n;
    if (n <= -32) return 0;
    return v >> (-n);
  endfunction

  task automatic predict_scan(element_t e);
    longint dt, decay, dbu, x, y, ex, sig, silu;
    int idx;
    scan_out_t r;
    idx = e.channel * NST + e.state_index;
    dt = longint'(e.step_raw) + longint'(e.step_bias);
    if (sp_en) dt = softplus(dt);
    decay = exp2q(shr(dt * e.a_coef, 12));
    dbu = shr(dt * e.b_val * e.u_val, 20);
    x = e.seq_start ? 0 : hstate[idx];
    x = clip32(shr(decay * x, 16) + dbu, clip_q);
    hstate[idx] = x;
    acc_q += shr(longint'(e.c_val) * x, 12);
    if (acc_q > 64'sd549755813887) begin acc_q = 64'sd549755813887; clip_q = 1; end
    if (acc_q < -64'sd549755813888) begin acc_q = -64'sd549755813888; clip_q = 1; end
    if (!e.last_element) return;
    y = acc_q;
    if (skip_en) y += shr(longint'(e.d_skip) * e.u_val, 8);
    if (gate_en) begin
      ex = exp2q(-longint'(e.z_val));
      sig = longint'((64'd1 << 32) / longint'(65536 + ex));
      silu = shr(longint'(e.z_val) * sig, 12);
      y = shr(y * silu, 16);
    end
    y = clip32(y, clip_q);
    r.channel_out = e.channel;
    r.y_value = y[31:0];
    r.saturated = clip_q;
    y_expected = {y_expected, r};
    acc_q = 0;
    clip_q = 0;
  endtask

  task automatic send_element(element_t e);
    if (!calm) while ($urandom_range(99) < 24) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    predict_scan(e);
    s_tvalid <= 1'b1;
    s_tdata <= {6'h0, e.z_val, e.d_skip, e.c_val, e.b_val, e.a_coef, e.u_val,
                e.step_bias, e.step_raw, e.state_index, e.channel};
    s_tlast <= e.last_element;
    s_tuser <= e.seq_start;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // result side: ready at random (always ready when calm), check each transfer
  always @(posedge clk) begin
    scan_out_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[37:0], m_tuser};
        got.channel_out = m_tdata[5:0];
        got.y_value = m_tdata[37:6];
        y_seen++;
        if (y_expected.size() == 0) begin
          errors++;
          $display("%0t: unexpected result ch=%0d y=%h", $time, got.channel_out, got.y_value);
        end else begin
          want = y_expected.pop_front();
          if (got.channel_out !== want.channel_out) begin
            errors++;
            $display("%0t: channel exp %0d got %0d", $time, want.channel_out, got.channel_out);
          end
          if (got.y_value !== want.y_value) begin
            errors++;
            $display("%0t: y_value exp %h got %h", $time, want.y_value, got.y_value);
          end
          if (got.saturated !== want.saturated) begin
            errors++;
            $display("%0t: saturated exp %b got %b", $time, want.saturated, got.saturated);
          end
        end
      end
      m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 24);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic v);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SOFTPLUS) sp_en = v;
    else if (idx == REG_SKIP) skip_en = v;
    else if (idx == REG_GATE) gate_en = v;
    @(posedge clk);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (y_expected.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_mode(bit sp, bit sk, bit gt);
    drain();
    write_reg(REG_SOFTPLUS, sp);
    write_reg(REG_SKIP, sk);
    write_reg(REG_GATE, gt);
  endtask

  function automatic element_t rand_element(int lanes, int span);
    element_t e;
    e = element_t'(EW'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    e.channel = 6'($urandom_range(lanes - 1));
    // mostly small magnitudes so the state stays meaningful, sometimes full range
    if ($urandom_range(3) != 0) begin
      e.step_raw = 16'($signed($urandom_range(2 * span)) - span);
      e.step_bias = 16'($signed($urandom_range(2 * span)) - span);
      e.a_coef = 16'(-$signed($urandom_range(8192)));
    end
    return e;
  endfunction

  task automatic test_directed;
    element_t e;
    int k;
    for (k = 0; k < 24; k++) begin
      e = '0;
      e.channel = (k & 1) ? 6'd63 : 6'd0;
      e.state_index = (k & 2) ? 4'd15 : 4'd0;
      e.seq_start = (k < 4);
      e.last_element = (k % 3 == 2);
      e.step_raw = (k & 4) ? 16'sh7FFF : -16'sh8000;
      e.step_bias = (k & 8) ? 16'sh7FFF : -16'sh8000;
      e.u_val = (k & 1) ? 16'sh7FFF : -16'sh8000;
      e.a_coef = (k & 16) ? 16'sh7FFF : -16'sh8000;
      e.b_val = (k & 2) ? -16'sh8000 : 16'sh7FFF;
      e.c_val = (k & 4) ? 16'sh7FFF : -16'sh8000;
      e.d_skip = (k & 8) ? -16'sh8000 : 16'sh7FFF;
      e.z_val = (k & 16) ? -16'sh8000 : 16'sh7FFF;
      if (k >= 20) begin
        e.step_raw = 16'sh0400; e.step_bias = 16'sh0000; e.a_coef = -16'sh1000;
        e.u_val = 16'sh1000; e.b_val = 16'sh1000; e.c_val = 16'sh1000;
        e.z_val = 16'sh0000; e.d_skip = 16'sh1000;
      end
      send_element(e);
      if (k == 11) set_mode(1, 1, 1);
    end
  endtask

  // sequences of up to NST elements on one channel, usually all; the last always emits
  task automatic test_random_scan(int seqs, int lanes);
    element_t e;
    logic [5:0] ch;
    int s, j, n;
    for (s = 0; s < seqs; s++) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(1, NST) : NST;
      e = rand_element(lanes, 2048);
      ch = e.channel;
      for (j = 0; j < n; j++) begin
        e = rand_element(lanes, 2048);
        e.channel = ch;
        e.state_index = 4'(j);
        e.seq_start = ($urandom_range(15) == 0);
        e.last_element = (j == n - 1) || ($urandom_range(40) == 0);
        send_element(e);
      end
    end
  endtask

  initial begin
    sp_en = 0; skip_en = 0; gate_en = 0;
    acc_q = 0; clip_q = 0;
    foreach (hstate[i]) hstate[i] = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    set_mode(0, 0, 0);
    test_random_scan(12, 4);
    set_mode(1, 0, 0);
    test_random_scan(12, 64);
    calm = 1'b1;
    set_mode(0, 1, 0);
    test_random_scan(12, 8);
    calm = 1'b0;
    set_mode(0, 0, 1);
    test_random_scan(12, 64);
    set_mode(1, 1, 1);
    test_random_scan(16, 64);
    drain();
    write_reg(2'd3, 1'b1);  // unused index, must have no effect
    test_random_scan(4, 64);
    drain();
    $display("Sent %0d elements over five register settings; checked %0d outputs.",
             items_sent, y_seen);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
